// ===== sv/imu_dfr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the IMU frame deframer.
package imu_dfr_pkg;

    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_VALUE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RAW_TYPE       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_EULER_TYPE     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_QUAT_TYPE      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BARO_TYPE      = 3'd5;

    localparam logic [7:0] MIN_FRAME     = 8'd5;
    localparam logic [7:0] LEN_POS       = 8'd3;
    localparam int         ADDR_POS      = 1;
    localparam int         LENGTH_POS    = 2;
    localparam int         TYPE_POS      = 3;
    localparam int         PAYLOAD_FIRST = 4;
    localparam int         PAYLOAD_BYTES = 18;
    localparam int         STORE_DEPTH   = PAYLOAD_FIRST + PAYLOAD_BYTES;
    localparam int         STORE_IDX_W   = $clog2(STORE_DEPTH);

    typedef enum logic [1:0] {
        KIND_RAW   = 2'd0,
        KIND_EULER = 2'd1,
        KIND_QUAT  = 2'd2,
        KIND_BARO  = 2'd3
    } record_kind_t;

    typedef struct packed {
        record_kind_t                   kind;
        logic [8*PAYLOAD_BYTES-1:0]     data;
    } burst_t;

    function automatic logic [3:0] last_index(input record_kind_t kind);
        logic [3:0] idx;
        unique case (kind)
            KIND_RAW:   idx = 4'd8;
            KIND_EULER: idx = 4'd2;
            KIND_QUAT:  idx = 4'd3;
            KIND_BARO:  idx = 4'd3;
            default:    idx = 4'd3;
        endcase
        return idx;
    endfunction

endpackage

// ===== sv/imu_frame_deframer.sv =====
`timescale 1ns / 1ps
// Byte-serial sync/address/length/checksum frame parser emitting IMU record words.
//
// Channel  Direction  Handshake          Payload
// s_       in         s_valid/s_ready    s_rx_byte
// m_       out        m_valid/m_ready    m_record_kind, m_word_index, m_word_value, m_last_word
// cfg_     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// One received byte is accepted per cycle; the parser state updates at the accepting edge.
// A completed, accepted frame is snapshotted into a one-entry holding register and then
// emitted from the output register at one word per cycle if m_ready is high (9, 3 or 4 words).
// Input stalls only while a second completed record waits behind a burst in progress.
// Synchronous active-low reset restores the register defaults and clears the frame store.
module imu_frame_deframer
    import imu_dfr_pkg::*;
#(
    parameter int MAX_FRAME = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_rx_byte,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [1:0]             m_record_kind,
    output logic [3:0]             m_word_index,
    output logic [31:0]            m_word_value,
    output logic                   m_last_word,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data
);

    localparam logic [7:0] MaxFrameB = 8'(MAX_FRAME);

    logic [7:0] sync_value_reg;
    logic [7:0] device_address_reg;
    logic [7:0] raw_type_reg;
    logic [7:0] euler_type_reg;
    logic [7:0] quat_type_reg;
    logic [7:0] baro_type_reg;

    logic       in_frame_reg, in_frame_next;
    logic [7:0] pos_reg, pos_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] store_reg [STORE_DEPTH];
    logic [7:0] store_next [STORE_DEPTH];

    logic       pend_valid_reg;
    burst_t     pend_reg;
    logic       emit_req;
    burst_t     emit_burst;

    logic                       em_valid_reg;
    record_kind_t               em_kind_reg;
    logic [3:0]                 em_index_reg;
    logic [8*PAYLOAD_BYTES-1:0] em_data_reg;

    logic       s_take;
    logic       m_take;
    logic       em_free;
    logic [7:0] pos_inc;
    logic [7:0] frame_len;

    assign cfg_ready = 1'b1;
    assign s_ready   = !pend_valid_reg || em_free;
    assign s_take    = s_valid && s_ready;
    assign m_take    = em_valid_reg && m_ready;
    assign pos_inc   = pos_reg + 8'd1;
    assign frame_len = (pos_reg == 8'(LENGTH_POS)) ? s_rx_byte : store_reg[LENGTH_POS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_value_reg     <= 8'd126;
            device_address_reg <= 8'd0;
            raw_type_reg       <= 8'd1;
            euler_type_reg     <= 8'd2;
            quat_type_reg      <= 8'd3;
            baro_type_reg      <= 8'd4;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_SYNC_VALUE:     sync_value_reg     <= cfg_data;
                REG_DEVICE_ADDRESS: device_address_reg <= cfg_data;
                REG_RAW_TYPE:       raw_type_reg       <= cfg_data;
                REG_EULER_TYPE:     euler_type_reg     <= cfg_data;
                REG_QUAT_TYPE:      quat_type_reg      <= cfg_data;
                REG_BARO_TYPE:      baro_type_reg      <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Parser: one byte of frame state update per accepted item.
    always_comb begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        store_next    = store_reg;
        emit_req      = 1'b0;
        emit_burst    = '0;
        if (s_take) begin
            if (!in_frame_reg) begin
                if (s_rx_byte == sync_value_reg) begin
                    store_next[0] = s_rx_byte;
                    pos_next      = 8'd1;
                    sum_next      = s_rx_byte;
                    in_frame_next = 1'b1;
                end
            end else if (pos_reg >= MaxFrameB) begin
                in_frame_next = 1'b0;
                pos_next      = 8'd0;
            end else begin
                if (pos_reg < 8'(STORE_DEPTH)) begin
                    store_next[pos_reg[STORE_IDX_W-1:0]] = s_rx_byte;
                end
                pos_next = pos_inc;
                sum_next = sum_reg + s_rx_byte;
                if (pos_inc >= LEN_POS) begin
                    if (frame_len < MIN_FRAME || frame_len > MaxFrameB) begin
                        in_frame_next = 1'b0;
                        pos_next      = 8'd0;
                        if (s_rx_byte == sync_value_reg) begin
                            store_next[0] = s_rx_byte;
                            pos_next      = 8'd1;
                            sum_next      = s_rx_byte;
                            in_frame_next = 1'b1;
                        end
                    end else if (pos_inc >= frame_len) begin
                        in_frame_next = 1'b0;
                        pos_next      = 8'd0;
                        if (store_reg[ADDR_POS] == device_address_reg
                                && sum_reg == s_rx_byte) begin
                            emit_req = 1'b1;
                            priority if (store_reg[TYPE_POS] == raw_type_reg) begin
                                emit_burst.kind = KIND_RAW;
                            end else if (store_reg[TYPE_POS] == euler_type_reg) begin
                                emit_burst.kind = KIND_EULER;
                            end else if (store_reg[TYPE_POS] == quat_type_reg) begin
                                emit_burst.kind = KIND_QUAT;
                            end else if (store_reg[TYPE_POS] == baro_type_reg) begin
                                emit_burst.kind = KIND_BARO;
                            end else begin
                                emit_req = 1'b0;
                            end
                        end
                    end
                end
            end
        end
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            emit_burst.data[8*i +: 8] = store_next[PAYLOAD_FIRST + i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            pos_reg      <= 8'd0;
            sum_reg      <= 8'd0;
            for (int i = 0; i < STORE_DEPTH; i++) begin
                store_reg[i] <= 8'd0;
            end
        end else begin
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
            sum_reg      <= sum_next;
            store_reg    <= store_next;
        end
    end

    // The output register is free when empty or when its last word leaves this cycle.
    assign em_free = !em_valid_reg || (m_take && em_index_reg == last_index(em_kind_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (emit_req) begin
            pend_valid_reg <= 1'b1;
        end else if (em_free) begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_req) begin
            pend_reg <= emit_burst;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            em_valid_reg <= 1'b0;
            em_index_reg <= 4'd0;
        end else if (em_free) begin
            em_valid_reg <= pend_valid_reg;
            em_index_reg <= 4'd0;
        end else if (m_take) begin
            em_index_reg <= em_index_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (em_free) begin
            em_kind_reg <= pend_reg.kind;
            em_data_reg <= pend_reg.data;
        end else if (m_take) begin
            if (em_kind_reg == KIND_RAW) begin
                em_data_reg <= em_data_reg >> 16;
            end else begin
                em_data_reg <= em_data_reg >> 32;
            end
        end
    end

    assign m_valid       = em_valid_reg;
    assign m_record_kind = em_kind_reg;
    assign m_word_index  = em_index_reg;
    assign m_last_word   = em_index_reg == last_index(em_kind_reg);
    assign m_word_value  = (em_kind_reg == KIND_RAW)
                         ? {{16{em_data_reg[15]}}, em_data_reg[15:0]}
                         : em_data_reg[31:0];

endmodule

// ===== test/tb_imu_frame_deframer.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the IMU frame deframer with a built-in frame predictor.
module tb_imu_frame_deframer;
    import imu_dfr_pkg::*;

    localparam int FRAME_MAX    = 32;
    localparam int SETTLE       = 16;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_BYTES = 36;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct {
        record_kind_t kind;
        logic [3:0]   index;
        logic [31:0]  value;
        logic         last;
    } word_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic [7:0]             s_rx_byte;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [1:0]             m_record_kind;
    logic [3:0]             m_word_index;
    logic [31:0]            m_word_value;
    logic                   m_last_word;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [7:0]             cfg_data;

    logic [7:0] sync_code;
    logic [7:0] own_address;
    logic [7:0] raw_code;
    logic [7:0] euler_code;
    logic [7:0] quat_code;
    logic [7:0] baro_code;

    bit         parsing;
    logic [7:0] fill;
    logic [7:0] byte_sum;
    logic [7:0] frame_copy [FRAME_MAX];

    word_t pending_words [$];
    int    error_count = 0;
    int    bytes_sent = 0;
    int    quiet_cycles = 0;
    int    hold_off_left = 0;
    int    sender_idle_pct = 0;
    int    receiver_idle_pct = 0;

    imu_frame_deframer #(
        .MAX_FRAME(FRAME_MAX)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_rx_byte(s_rx_byte),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_record_kind(m_record_kind),
        .m_word_index(m_word_index),
        .m_word_value(m_word_value),
        .m_last_word(m_last_word),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic void flag_error(input string what);
        error_count++;
        if (error_count <= 10) begin
            $display("ERROR at %0t ns: %s", $time, what);
        end
    endfunction

    function automatic void reset_predictor();
        sync_code   = 8'd126;
        own_address = 8'd0;
        raw_code    = 8'd1;
        euler_code  = 8'd2;
        quat_code   = 8'd3;
        baro_code   = 8'd4;
        parsing     = 1'b0;
        fill        = 8'd0;
        byte_sum    = 8'd0;
        for (int i = 0; i < FRAME_MAX; i++) begin
            frame_copy[i] = 8'd0;
        end
    endfunction

    function automatic void open_frame(input logic [7:0] b);
        frame_copy[0] = b;
        fill          = 8'd1;
        byte_sum      = b;
        parsing       = 1'b1;
    endfunction

    function automatic void queue_record();
        record_kind_t kind;
        int           count;
        int           p;
        logic [31:0]  v;
        word_t        w;
        if (frame_copy[TYPE_POS] == raw_code) begin
            kind = KIND_RAW;
            count = 9;
        end else if (frame_copy[TYPE_POS] == euler_code) begin
            kind = KIND_EULER;
            count = 3;
        end else if (frame_copy[TYPE_POS] == quat_code) begin
            kind = KIND_QUAT;
            count = 4;
        end else if (frame_copy[TYPE_POS] == baro_code) begin
            kind = KIND_BARO;
            count = 4;
        end else begin
            return;
        end
        for (int i = 0; i < count; i++) begin
            if (kind == KIND_RAW) begin
                p = PAYLOAD_FIRST + 2 * i;
                v = {{16{frame_copy[p+1][7]}}, frame_copy[p+1], frame_copy[p]};
            end else begin
                p = PAYLOAD_FIRST + 4 * i;
                v = {frame_copy[p+3], frame_copy[p+2], frame_copy[p+1], frame_copy[p]};
            end
            w.kind  = kind;
            w.index = 4'(i);
            w.value = v;
            w.last  = (i == count - 1);
            pending_words.push_back(w);
        end
    endfunction

    function automatic void predict_byte(input logic [7:0] b);
        logic [7:0] sum_prior;
        logic [7:0] frame_len;
        if (!parsing) begin
            if (b == sync_code) begin
                open_frame(b);
            end
            return;
        end
        if (fill >= FRAME_MAX) begin
            parsing = 1'b0;
            fill = 8'd0;
            return;
        end
        frame_copy[fill] = b;
        fill = fill + 8'd1;
        sum_prior = byte_sum;
        byte_sum = byte_sum + b;
        if (fill < LEN_POS) begin
            return;
        end
        frame_len = frame_copy[LENGTH_POS];
        if (frame_len < MIN_FRAME || frame_len > FRAME_MAX) begin
            parsing = 1'b0;
            fill = 8'd0;
            if (b == sync_code) begin
                open_frame(b);
            end
            return;
        end
        if (fill >= frame_len) begin
            parsing = 1'b0;
            fill = 8'd0;
            if (frame_copy[ADDR_POS] == own_address && sum_prior == b) begin
                queue_record();
            end
        end
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predict_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input bit with_sync, input logic [7:0] addr,
                              input logic [7:0] len, input logic [7:0] code,
                              input bit bad_sum);
        logic [7:0] sum;
        logic [7:0] b;
        sum = 8'd0;
        for (int i = 0; i < len - 1; i++) begin
            case (i)
                0:       b = sync_code;
                1:       b = addr;
                2:       b = len;
                3:       b = code;
                default: b = 8'($urandom);
            endcase
            sum = sum + b;
            if (i > 0 || with_sync) begin
                send_byte(b);
            end
        end
        send_byte(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_words.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        case (idx)
            REG_SYNC_VALUE:     sync_code = val;
            REG_DEVICE_ADDRESS: own_address = val;
            REG_RAW_TYPE:       raw_code = val;
            REG_EULER_TYPE:     euler_code = val;
            REG_QUAT_TYPE:      quat_code = val;
            REG_BARO_TYPE:      baro_code = val;
            default:            ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_default_records();
        send_frame(1'b1, own_address, 8'd32, raw_code, 1'b0);
        send_frame(1'b1, own_address, 8'd17, euler_code, 1'b0);
        send_frame(1'b1, own_address, 8'd21, quat_code, 1'b0);
        send_frame(1'b1, own_address, 8'd5, baro_code, 1'b0);
        send_frame(1'b1, own_address, 8'd22, raw_code, 1'b0);
    endtask

    task automatic test_frame_special_cases();
        // Out-of-range lengths abort the frame.
        send_byte(sync_code); send_byte(own_address); send_byte(8'd4);
        send_byte(sync_code); send_byte(own_address); send_byte(8'd33);
        send_byte(sync_code); send_byte(own_address); send_byte(8'd0);
        send_byte(sync_code); send_byte(own_address); send_byte(8'd255);
        // A length byte equal to sync aborts and restarts the frame.
        send_byte(sync_code); send_byte(own_address); send_byte(sync_code);
        send_frame(1'b0, own_address, 8'd5, quat_code, 1'b0);
        // Rejected frames: wrong address, wrong checksum, unknown type.
        send_frame(1'b1, own_address ^ 8'h01, 8'd5, euler_code, 1'b0);
        send_frame(1'b1, own_address, 8'd6, euler_code, 1'b1);
        send_frame(1'b1, own_address, 8'd5, 8'h99, 1'b0);
        // A checksum equal to sync completes the frame without starting another.
        send_byte(sync_code); send_byte(8'd0); send_byte(8'd6); send_byte(raw_code);
        send_byte(8'd249); send_byte(8'd126);
        send_byte(8'd0);
        send_frame(1'b1, own_address, 8'd9, euler_code, 1'b0);
    endtask

    task automatic test_type_priority();
        drain();
        write_reg(REG_SYNC_VALUE, 8'd0);
        write_reg(REG_DEVICE_ADDRESS, 8'd255);
        write_reg(REG_RAW_TYPE, 8'd255);
        write_reg(REG_EULER_TYPE, 8'd0);
        write_reg(REG_QUAT_TYPE, 8'd128);
        write_reg(REG_BARO_TYPE, 8'd127);
        write_reg(REG_SPARE_LO, 8'hAA);
        write_reg(REG_SPARE_HI, 8'h55);
        send_frame(1'b1, own_address, 8'd22, raw_code, 1'b0);
        send_frame(1'b1, own_address, 8'd17, euler_code, 1'b0);
        send_frame(1'b1, own_address, 8'd5, quat_code, 1'b0);
        send_frame(1'b1, own_address, 8'd21, baro_code, 1'b0);
        drain();
        write_reg(REG_SYNC_VALUE, 8'd255);
        write_reg(REG_DEVICE_ADDRESS, 8'd0);
        write_reg(REG_RAW_TYPE, 8'd7);
        write_reg(REG_EULER_TYPE, 8'd7);
        write_reg(REG_QUAT_TYPE, 8'd7);
        write_reg(REG_BARO_TYPE, 8'd7);
        send_frame(1'b1, own_address, 8'd6, 8'd7, 1'b0);
        drain();
        write_reg(REG_RAW_TYPE, 8'd8);
        send_frame(1'b1, own_address, 8'd6, 8'd7, 1'b0);
        drain();
        write_reg(REG_EULER_TYPE, 8'd8);
        send_frame(1'b1, own_address, 8'd6, 8'd7, 1'b0);
        drain();
        write_reg(REG_QUAT_TYPE, 8'd8);
        send_frame(1'b1, own_address, 8'd6, 8'd7, 1'b0);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_bytes);
        int         start;
        int         pick;
        logic [7:0] len;
        logic [7:0] code;
        drain();
        sender_idle_pct   = send_pct;
        receiver_idle_pct = recv_pct;
        write_reg(REG_SYNC_VALUE, 8'($urandom));
        write_reg(REG_DEVICE_ADDRESS, 8'($urandom));
        write_reg(REG_RAW_TYPE, 8'($urandom));
        write_reg(REG_EULER_TYPE, ($urandom_range(0, 4) == 0) ? raw_code : 8'($urandom));
        write_reg(REG_QUAT_TYPE, 8'($urandom));
        write_reg(REG_BARO_TYPE, ($urandom_range(0, 4) == 0) ? quat_code : 8'($urandom));
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                len = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(23, FRAME_MAX))
                                                  : 8'($urandom_range(5, 22));
                case ($urandom_range(0, 9))
                    0, 1:    code = raw_code;
                    2, 3:    code = euler_code;
                    4, 5:    code = quat_code;
                    6, 7:    code = baro_code;
                    default: code = 8'($urandom);
                endcase
                send_frame(1'b1,
                           ($urandom_range(0, 9) == 0) ? own_address ^ 8'($urandom_range(1, 255))
                                                       : own_address,
                           len, code, $urandom_range(0, 9) == 0);
            end else if (pick < 80) begin
                send_byte(sync_code);
                send_byte(own_address);
                if ($urandom_range(0, 3) == 0) begin
                    send_byte(sync_code);
                end else if ($urandom_range(0, 1) == 0) begin
                    send_byte(8'($urandom_range(0, 4)));
                end else begin
                    send_byte(8'($urandom_range(FRAME_MAX + 1, 255)));
                end
            end else if (pick < 90) begin
                send_byte(sync_code);
                send_byte(own_address);
                send_byte(8'($urandom_range(5, 22)));
                repeat ($urandom_range(0, 4)) send_byte(8'($urandom));
            end else begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end
        end
        drain();
    endtask

    task automatic test_backpressure();
        drain();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_off_left     = HOLD_CYCLES;
        repeat (12) send_frame(1'b1, own_address, 8'd5, quat_code, 1'b0);
        drain();
    endtask

    always @(posedge aclk) begin
        if (hold_off_left > 0) begin
            hold_off_left <= hold_off_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        word_t w;
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                flag_error($sformatf("unexpected word kind=%0d index=%0d value=%08h last=%0b",
                                     m_record_kind, m_word_index, m_word_value, m_last_word));
            end else begin
                w = pending_words.pop_front();
                if (m_record_kind !== w.kind || m_word_index !== w.index ||
                    m_word_value !== w.value || m_last_word !== w.last) begin
                    flag_error($sformatf({"word mismatch: expected kind=%0d index=%0d ",
                                          "value=%08h last=%0b, got kind=%0d index=%0d ",
                                          "value=%08h last=%0b"},
                                         w.kind, w.index, w.value, w.last, m_record_kind,
                                         m_word_index, m_word_value, m_last_word));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_rx_byte <= 8'd0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_SYNC_VALUE;
        cfg_data  <= 8'd0;
        reset_predictor();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        sender_idle_pct   = 33;
        receiver_idle_pct = 78;
        test_default_records();
        test_frame_special_cases();
        test_type_priority();
        test_random_traffic(33, 78, RANDOM_BYTES);
        test_random_traffic(78, 33, RANDOM_BYTES);
        test_random_traffic(0, 0, RANDOM_BYTES);
        test_backpressure();
        repeat (SETTLE) @(posedge aclk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/imu_dfr_pkg.sv
sv/imu_frame_deframer.sv
test/tb_imu_frame_deframer.sv
